// ===== design/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

  localparam int WordBits   = 64;
  localparam int BlockWords = 16;
  localparam int RoundCount = 80;
  localparam int DigestWords = 4;

  localparam logic [63:0] IV [8] = '{
    64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2,
    64'h2393B86B6F53B151, 64'h963877195940EABD,
    64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
    64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [4:0] LenWord = 5'd14;   // 112 bytes, where the length starts
  localparam logic [4:0] FullWords = 5'd16; // 128 bytes

  typedef enum logic [2:0] {
    ST_IDLE, ST_MARK, ST_ZERO, ST_LEN_HI, ST_LEN_LO, ST_OUT, ST_ROUND, ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       absorb;
    logic       push_mark;
    logic       push_zero;
    logic       push_hi;
    logic       push_lo;
    logic       start;
    logic       round;
    logic       finish;
    logic       clear;
    logic [6:0] rnd;
    logic [1:0] oidx;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic at_len;
  } stat_t;

  function automatic logic [63:0] round_const(input logic [6:0] t);
    logic [63:0] k;
    case (t)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== design/sha512_256_hash_core.sv =====
`timescale 1ns / 1ps
// channel   | handshake            | payload
// message   | msg_valid/msg_stall  | data_word, valid_bytes, message_end
// digest    | dig_valid/dig_stall  | digest_word, digest_last
//
// a message word is taken while msg_stall is low; each 16th packed word is followed
// by a start, 80 rounds on one round unit and a final add, with msg_stall held high.
// message end adds 3 to 18 padding pushes, one or two compressions, then four
// digest words one per cycle while dig_stall is low. rst is synchronous and clears
// control and counters; a stalled digest word holds.
module sha512_256_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        message_end,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [63:0] digest_word,
  output logic        digest_last
);
  import sha_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .msg_valid(msg_valid), .message_end(message_end),
    .dig_stall(dig_stall), .stat(stat), .cmd(cmd), .msg_stall(msg_stall),
    .dig_valid(dig_valid), .digest_last(digest_last)
  );

  // packing, schedule and rounds
  sha_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_word(data_word),
    .valid_bytes(valid_bytes), .stat(stat), .digest_word(digest_word)
  );

endmodule

// ===== design/sha_ctrl.sv =====
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          msg_valid,
  input  logic          message_end,
  input  logic          dig_stall,
  input  sha_pkg::stat_t stat,
  output sha_pkg::cmd_t  cmd,
  output logic          msg_stall,
  output logic          dig_valid,
  output logic          digest_last
);
  import sha_pkg::*;

  state_t     state, state_next;
  state_t     resume;
  logic [6:0] rnd;
  logic [1:0] oidx;
  logic       msg_take, dig_take;

  assign msg_take = msg_valid && !msg_stall;
  assign dig_take = dig_valid && !dig_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_ROUND:  state_next = (rnd == 7'(RoundCount - 1)) ? ST_FINISH : ST_ROUND;
      ST_FINISH: state_next = resume;
      default: begin
        if (stat.full) begin
          state_next = ST_ROUND;
        end else begin
          case (state)
            ST_IDLE:   if (msg_take && message_end) state_next = ST_MARK;
            ST_MARK:   state_next = ST_ZERO;
            ST_ZERO:   if (stat.at_len) state_next = ST_LEN_HI;
            ST_LEN_HI: state_next = ST_LEN_LO;
            ST_LEN_LO: state_next = ST_OUT;
            ST_OUT:    if (dig_take && oidx == 2'(DigestWords - 1)) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.rnd   = rnd;
    cmd.oidx  = oidx;
    msg_stall = 1'b1;
    dig_valid = 1'b0;
    case (state)
      ST_ROUND:  cmd.round = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      default: begin
        if (stat.full) begin
          cmd.start = 1'b1;
        end else begin
          case (state)
            ST_IDLE: begin
              msg_stall  = 1'b0;
              cmd.absorb = msg_valid;
            end
            ST_MARK:   cmd.push_mark = 1'b1;
            ST_ZERO:   cmd.push_zero = !stat.at_len;
            ST_LEN_HI: cmd.push_hi = 1'b1;
            ST_LEN_LO: cmd.push_lo = 1'b1;
            ST_OUT: begin
              dig_valid = 1'b1;
              cmd.clear = dig_take && oidx == 2'(DigestWords - 1);
            end
            default: cmd = cmd;
          endcase
        end
      end
    endcase
  end

  assign digest_last = (oidx == 2'(DigestWords - 1));

  // state, return point, round and output counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      resume <= ST_IDLE;
      rnd    <= '0;
      oidx   <= '0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        resume <= state;
        rnd    <= '0;
      end else if (cmd.round) begin
        rnd <= rnd + 7'd1;
      end
      if (dig_take) oidx <= oidx + 2'd1;
    end
  end

endmodule

// ===== design/sha_dp.sv =====
`timescale 1ns / 1ps
module sha_dp (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::cmd_t  cmd,
  input  logic [63:0]   data_word,
  input  logic [3:0]    valid_bytes,
  output sha_pkg::stat_t stat,
  output logic [63:0]   digest_word
);
  import sha_pkg::*;

  logic [63:0] hash [8];
  logic [63:0] v [8];
  logic [63:0] win [BlockWords];
  logic [63:0] acc;
  logic [2:0]  acc_cnt;
  logic [4:0]  wcnt;
  logic [63:0] total;

  logic [3:0]   cnt;
  logic [63:0]  dmask;
  logic [127:0] comb_bytes;
  logic [3:0]   sum_cnt;
  logic [63:0]  mark_word;
  logic         push;
  logic [63:0]  push_word;

  logic [63:0] s0w, s1w, new_w;
  logic [63:0] big_s1, ch, t1, big_s0, mj, t2;

  // byte packing of the incoming word behind the held partial word
  always_comb begin
    cnt        = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    dmask      = data_word & ~(64'hFFFF_FFFF_FFFF_FFFF >> {cnt, 3'b000});
    comb_bytes = {acc, 64'h0} | ({dmask, 64'h0} >> {acc_cnt, 3'b000});
    sum_cnt    = {1'b0, acc_cnt} + cnt;
    mark_word  = acc | ({PadMark, 56'h0} >> {acc_cnt, 3'b000});
  end

  // word pushed into the block this cycle
  always_comb begin
    push      = 1'b0;
    push_word = '0;
    if (cmd.absorb && sum_cnt[3]) begin
      push      = 1'b1;
      push_word = comb_bytes[127:64];
    end else if (cmd.push_mark) begin
      push      = 1'b1;
      push_word = mark_word;
    end else if (cmd.push_zero) begin
      push = 1'b1;
    end else if (cmd.push_hi) begin
      push      = 1'b1;
      push_word = {61'h0, total[63:61]};
    end else if (cmd.push_lo) begin
      push      = 1'b1;
      push_word = {total[60:0], 3'b000};
    end
  end

  // schedule expansion and round function
  always_comb begin
    s0w    = {win[1][0], win[1][63:1]} ^ {win[1][7:0], win[1][63:8]} ^ (win[1] >> 7);
    s1w    = {win[14][18:0], win[14][63:19]} ^ {win[14][60:0], win[14][63:61]}
             ^ (win[14] >> 6);
    new_w  = win[0] + s0w + win[9] + s1w;
    big_s1 = {v[4][13:0], v[4][63:14]} ^ {v[4][17:0], v[4][63:18]}
             ^ {v[4][40:0], v[4][63:41]};
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = v[7] + big_s1 + ch + round_const(cmd.rnd) + win[0];
    big_s0 = {v[0][27:0], v[0][63:28]} ^ {v[0][33:0], v[0][63:34]}
             ^ {v[0][38:0], v[0][63:39]};
    mj     = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2     = big_s0 + mj;
  end

  // block window: shifts on every push and every round
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < BlockWords - 1; i++) win[i] <= win[i + 1];
      win[BlockWords - 1] <= push_word;
    end else if (cmd.round) begin
      for (int i = 0; i < BlockWords - 1; i++) win[i] <= win[i + 1];
      win[BlockWords - 1] <= new_w;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // chaining value and counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 8; i++) hash[i] <= IV[i];
      acc_cnt <= '0;
      wcnt    <= '0;
      total   <= '0;
      acc     <= '0;
    end else begin
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
        wcnt <= '0;
      end else if (push) begin
        wcnt <= wcnt + 5'd1;
      end
      if (cmd.absorb) begin
        total <= total + 64'(cnt);
        if (sum_cnt[3]) begin
          acc     <= comb_bytes[63:0];
          acc_cnt <= sum_cnt[2:0];
        end else begin
          acc     <= comb_bytes[127:64];
          acc_cnt <= sum_cnt[2:0];
        end
      end else if (cmd.push_mark) begin
        acc     <= '0;
        acc_cnt <= '0;
      end
    end
  end

  assign stat.full   = (wcnt == FullWords);
  assign stat.at_len = (wcnt == LenWord);
  assign digest_word = hash[{1'b0, cmd.oidx}];

endmodule

// ===== design/sha_chk.sv =====
`timescale 1ns / 1ps
module sha_chk (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_stall,
  input logic        message_end,
  input logic        dig_valid,
  input logic        dig_stall,
  input logic [63:0] digest_word,
  input logic        digest_last
);

  // held digest transaction keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_stall |=> dig_valid && $stable(digest_word))
    else $error("digest word changed while stalled");

  // no message transaction while the digest is shown
  a_excl: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> msg_stall)
    else $error("message taken during digest");

  // end of message closes the input
  a_end: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_stall && message_end |=> msg_stall && !dig_valid)
    else $error("input open after message end");

  // last digest word returns to idle
  a_last: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && digest_last |=> !dig_valid && !msg_stall)
    else $error("no return to idle after digest");

endmodule

bind sha512_256_hash_core sha_chk u_chk (
  .clk(clk), .rst(rst), .msg_valid(msg_valid), .msg_stall(msg_stall),
  .message_end(message_end), .dig_valid(dig_valid), .dig_stall(dig_stall),
  .digest_word(digest_word), .digest_last(digest_last)
);
